// ===== rtl/ssr_pkg.sv =====
package ssr_pkg;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 64;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [7:0]          byte_t;
  typedef logic [3:0]          len_t;

  localparam cfg_idx_t CFG_PATTERN_BYTES      = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_PATTERN_LENGTH     = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_REPLACEMENT_BYTES  = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_REPLACEMENT_LENGTH = cfg_idx_t'(3);

endpackage

// ===== rtl/stream_search_replace.sv =====
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    in_byte, end_of_stream
// out       source     out_valid / out_ready  out_byte, has_byte, last
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input byte is matched against the window in the cycle it is accepted; its results
// are loaded into a burst register and leave one per cycle while out_ready is high, so a
// byte that yields at most one result sustains one transaction per cycle. A replacement
// or an end-of-stream flush of N results holds in_ready low while the burst drains.
// Synchronous reset empties the window and the burst register and restores the registers.
// in_ready follows out_ready combinationally on the last result of a burst.
module stream_search_replace
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACE = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  byte_t     in_byte,
  input  logic      end_of_stream,
  output logic      out_valid,
  input  logic      out_ready,
  output byte_t     out_byte,
  output logic      has_byte,
  output logic      last,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data
);

  localparam int BurstN = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int FillW  = $clog2(MAX_PATTERN + 1);
  localparam int CntW   = $clog2(BurstN + 1);
  localparam int IdxW   = (BurstN > 1) ? $clog2(BurstN) : 1;

  // configuration
  cfg_data_t pattern_bytes;
  len_t      pattern_length;
  cfg_data_t replacement_bytes;
  len_t      replacement_length;

  // window
  byte_t            win [MAX_PATTERN];
  logic [FillW-1:0] fill;

  // burst register
  byte_t           bq_byte [BurstN];
  logic [CntW-1:0] bq_cnt;
  logic [IdxW-1:0] bq_idx;
  logic            bq_has;
  logic            bq_eos;
  logic            busy;

  len_t             plen_sat;
  len_t             rlen_sat;
  logic [FillW-1:0] plen;
  logic [CntW-1:0]  rlen;
  logic [FillW-1:0] fill0;
  logic [FillW-1:0] nf;
  byte_t            wnew [MAX_PATTERN];
  byte_t            win_next [MAX_PATTERN];
  logic [FillW-1:0] fill_next;
  byte_t            res_byte [BurstN];
  logic [CntW-1:0]  cnt;
  logic [CntW-1:0]  res_cnt;
  logic             res_has;
  logic             full;
  logic             match;
  logic             hit;
  logic             tail;
  logic             out_fire;
  logic             done;
  logic             in_fire;

  always_comb begin
    plen_sat = (pattern_length == '0) ? len_t'(1) : pattern_length;
    if (plen_sat > len_t'(MAX_PATTERN)) plen_sat = len_t'(MAX_PATTERN);
    plen = plen_sat[FillW-1:0];
    rlen_sat = replacement_length;
    if (rlen_sat > len_t'(MAX_REPLACE)) rlen_sat = len_t'(MAX_REPLACE);
    rlen = rlen_sat[CntW-1:0];
  end

  always_comb begin
    fill0 = (fill >= plen) ? '0 : fill;
    nf    = fill0 + FillW'(1);
    full  = (nf == plen);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wnew[i] = (FillW'(i) == fill0) ? in_byte : win[i];
    end
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FillW'(i) < plen && wnew[i] != pattern_bytes[8*i +: 8]) match = 1'b0;
    end
    hit = full && match;

    for (int i = 0; i < BurstN; i++) begin
      res_byte[i] = '0;
      if (hit) begin
        if (i < MAX_REPLACE) res_byte[i] = replacement_bytes[8*i +: 8];
      end else begin
        if (i < MAX_PATTERN) res_byte[i] = wnew[i];
      end
    end

    if (hit)                cnt = rlen;
    else if (end_of_stream) cnt = CntW'(nf);
    else if (full)          cnt = CntW'(1);
    else                    cnt = '0;

    // a flush with nothing to emit still sends a bare end marker
    res_has = !(end_of_stream && cnt == '0);
    res_cnt = res_has ? cnt : CntW'(1);

    if (end_of_stream || hit) fill_next = '0;
    else if (full)            fill_next = plen - FillW'(1);
    else                      fill_next = nf;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_next[i] = wnew[i];
      if (full && !hit && i < MAX_PATTERN - 1) win_next[i] = wnew[i + 1];
    end
  end

  assign tail      = (CntW'(bq_idx) + CntW'(1) == bq_cnt);
  assign out_valid = busy;
  assign out_byte  = bq_has ? bq_byte[bq_idx] : '0;
  assign has_byte  = bq_has;
  assign last      = bq_eos && tail;
  assign out_fire  = busy && out_ready;
  assign done      = out_fire && tail;
  assign in_ready  = !busy || done;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_PATTERN; i++) win[i] <= win_next[i];
      if (res_cnt != '0) begin
        for (int i = 0; i < BurstN; i++) bq_byte[i] <= res_byte[i];
        bq_cnt <= res_cnt;
        bq_has <= res_has;
        bq_eos <= end_of_stream;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill               <= '0;
      busy               <= 1'b0;
      bq_idx             <= '0;
      pattern_bytes      <= '0;
      pattern_length     <= len_t'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == CFG_PATTERN_LENGTH) begin
        fill <= '0;  // drop the window
      end else if (in_fire) begin
        fill <= fill_next;
      end

      if (in_fire && res_cnt != '0) begin
        busy   <= 1'b1;
        bq_idx <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (out_fire) begin
        bq_idx <= bq_idx + IdxW'(1);
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
          CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
          CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
          CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ssr_checker.sv =====
module ssr_props
  import ssr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input byte_t     out_byte,
  input logic      has_byte,
  input logic      last
);

  // a stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte)
      && $stable(last))
    else $error("output changed while stalled");

  // a bare marker only closes a stream
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last && out_byte == '0)
    else $error("bare marker without last or with data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // with nothing pending the block always takes input
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending output");

endmodule

bind stream_search_replace ssr_props u_ssr_props (.*);
